[src/quaternion_to_heading_top_defines.svh]
// Assertion macros for the quaternion-to-heading block.
// Used by the top level; no other dependencies.
`ifndef QUATERNION_TO_HEADING_TOP_DEFINES_SVH
`define QUATERNION_TO_HEADING_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define QTH_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset
`define QTH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QTH_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define QTH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[src/qth_pkg.sv]
// Shared widths, types and constants of the quaternion-to-heading block.
// No dependencies.
`timescale 1ns / 1ps

package qth_pkg;

    localparam int QTH_QW        = 16;  // quaternion component
    localparam int QTH_PW        = 32;  // 16x16 product
    localparam int QTH_RW        = 34;  // r1 / r4 in 2^-28 units
    localparam int QTH_CW        = 53;  // CORDIC x / y datapath
    localparam int QTH_AW        = 30;  // angle in 2^-20 degree
    localparam int QTH_HW        = 16;  // heading
    localparam int QTH_TABLE_LEN = 24;

    localparam int QTH_CORDIC_STAGES_DEF = 16;
    localparam int QTH_FRAC_SHIFT        = 16;
    localparam int QTH_ROUND_SHIFT       = 13;

    typedef logic signed [QTH_QW-1:0] t_quat;
    typedef logic signed [QTH_PW-1:0] t_prod;
    typedef logic signed [QTH_RW-1:0] t_rv;
    typedef logic signed [QTH_CW-1:0] t_cv;
    typedef logic signed [QTH_AW-1:0] t_ang;
    typedef logic        [QTH_HW-1:0] t_head;

    localparam t_rv   QTH_R_ONE      = t_rv'(268435456);   // 1.0 in 2^-28 units
    localparam t_ang  QTH_QUARTER    = t_ang'(94371840);   // 90 degrees
    localparam t_ang  QTH_FULL_TURN  = t_ang'(377487360);  // 360 degrees
    localparam t_ang  QTH_ROUND_HALF = t_ang'(4096);       // half of 1/128 degree
    localparam t_head QTH_HEAD_LIMIT = t_head'(46080);     // 360 degrees in 1/128

    // atan(2^-i) in degrees, scaled by 2^20
    localparam t_ang QTH_ATAN_TAB [0:QTH_TABLE_LEN-1] = '{
        t_ang'(47185920), t_ang'(27855475), t_ang'(14718068), t_ang'(7471121),
        t_ang'(3750058),  t_ang'(1876857),  t_ang'(938658),   t_ang'(469357),
        t_ang'(234682),   t_ang'(117342),   t_ang'(58671),    t_ang'(29335),
        t_ang'(14668),    t_ang'(7334),     t_ang'(3667),     t_ang'(1833),
        t_ang'(917),      t_ang'(458),      t_ang'(229),      t_ang'(115),
        t_ang'(57),       t_ang'(29),       t_ang'(14),       t_ang'(7)
    };

    // One CORDIC pipeline slot
    typedef struct packed {
        t_cv  x;
        t_cv  y;
        t_ang z;
        logic zero;
    } t_cordic_st;

endpackage

[src/qth_quat_if.sv]
// Input channel: one quaternion item per valid/ready handshake.
// Depends on qth_pkg.
`timescale 1ns / 1ps

interface qth_quat_if import qth_pkg::*; ();
    logic  valid;
    logic  ready;
    t_quat quat_x;
    t_quat quat_y;
    t_quat quat_z;
    t_quat quat_w;

    modport source (output valid, output quat_x, output quat_y, output quat_z,
                    output quat_w, input ready);
    modport sink   (input valid, input quat_x, input quat_y, input quat_z,
                    input quat_w, output ready);
endinterface

[src/qth_head_if.sv]
// Output channel: one heading item per valid/ready handshake.
// Depends on qth_pkg.
`timescale 1ns / 1ps

interface qth_head_if import qth_pkg::*; ();
    logic  valid;
    logic  ready;
    t_head heading;

    modport source (output valid, output heading, input ready);
    modport sink   (input valid, input heading, output ready);
endinterface

[src/qth_prod.sv]
// Front end: products of the quaternion components, then r1 and r4.
// Two register stages; depends on qth_pkg.
`timescale 1ns / 1ps

module qth_prod import qth_pkg::*; (
    input  logic       i_clk,
    input  logic [1:0] i_en,
    input  t_quat      i_x,
    input  t_quat      i_y,
    input  t_quat      i_z,
    input  t_quat      i_w,
    output t_rv        o_r1,
    output t_rv        o_r4,
    output logic       o_zero
);

    t_prod r_xy, r_zw, r_xx, r_zz;
    t_rv   r_r1, r_r4;
    logic  r_zero;
    t_rv   n_r1, n_r4;

    // Stage 0: four 16x16 products
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_xy <= QTH_PW'(i_x) * QTH_PW'(i_y);
            r_zw <= QTH_PW'(i_z) * QTH_PW'(i_w);
            r_xx <= QTH_PW'(i_x) * QTH_PW'(i_x);
            r_zz <= QTH_PW'(i_z) * QTH_PW'(i_z);
        end
    end

    // Stage 1: r1 = 2xy - 2zw, r4 = 1 - 2x^2 - 2z^2
    always_comb begin
        n_r1 = (QTH_RW'(r_xy) <<< 1) - (QTH_RW'(r_zw) <<< 1);
        n_r4 = QTH_R_ONE - (QTH_RW'(r_xx) <<< 1) - (QTH_RW'(r_zz) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_r1   <= n_r1;
            r_r4   <= n_r4;
            r_zero <= (n_r1 == '0) && (n_r4 == '0);
        end
    end

    assign o_r1   = r_r1;
    assign o_r4   = r_r4;
    assign o_zero = r_zero;

endmodule

[src/qth_cordic.sv]
// Pipelined CORDIC vectoring unit: quadrant fold, then one iteration per stage.
// STAGES + 1 register stages; depends on qth_pkg.
`timescale 1ns / 1ps

module qth_cordic import qth_pkg::*; #(
    parameter int STAGES = QTH_CORDIC_STAGES_DEF
) (
    input  logic            i_clk,
    input  logic [STAGES:0] i_en,
    input  t_rv             i_r1,
    input  t_rv             i_r4,
    input  logic            i_zero,
    output t_cordic_st      o_st
);

    t_cordic_st stage_st [0:STAGES];
    t_cordic_st r_fold;
    t_cordic_st n_fold;
    t_cv        xin, yin;

    // Fold the left half plane by a quarter turn
    always_comb begin
        xin  = QTH_CW'(i_r4) <<< QTH_FRAC_SHIFT;
        yin  = QTH_CW'(i_r1) <<< QTH_FRAC_SHIFT;
        n_fold.zero = i_zero;
        if (xin[QTH_CW-1] == 1'b0) begin
            n_fold.x = xin;
            n_fold.y = yin;
            n_fold.z = '0;
        end else if (yin[QTH_CW-1] == 1'b0) begin
            n_fold.x = yin;
            n_fold.y = -xin;
            n_fold.z = QTH_QUARTER;
        end else begin
            n_fold.x = -yin;
            n_fold.y = xin;
            n_fold.z = -QTH_QUARTER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_fold <= n_fold;
        end
    end

    assign stage_st[0] = r_fold;

    // One micro-rotation per stage
    for (genvar g = 0; g < STAGES; g++) begin : g_iter
        t_cordic_st r_it;
        t_cordic_st n_it;
        t_cv        cx, cy, xs, ys;
        t_ang       cz;

        always_comb begin
            cx = stage_st[g].x;
            cy = stage_st[g].y;
            cz = stage_st[g].z;
            xs = cx >>> g;
            ys = cy >>> g;
            n_it.zero = stage_st[g].zero;
            if (cy[QTH_CW-1] == 1'b0) begin
                n_it.x = cx + ys;
                n_it.y = cy - xs;
                n_it.z = cz + QTH_ATAN_TAB[g];
            end else begin
                n_it.x = cx - ys;
                n_it.y = cy + xs;
                n_it.z = cz - QTH_ATAN_TAB[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[g+1]) begin
                r_it <= n_it;
            end
        end

        assign stage_st[g+1] = r_it;
    end

    assign o_st = stage_st[STAGES];

endmodule

[src/qth_heading.sv]
// Back end: wrap the angle to [0, 360), round to 1/128 degree, wrap 360 to 0.
// Two register stages; depends on qth_pkg.
`timescale 1ns / 1ps

module qth_heading import qth_pkg::*; (
    input  logic       i_clk,
    input  logic [1:0] i_en,
    input  t_cordic_st i_st,
    output t_head      o_heading
);

    t_head r_raw;
    logic  r_zero;
    t_head r_head;
    t_ang  n_sum;
    t_head n_head;

    // Stage 0: add a full turn to negative angles, add rounding half, drop fraction
    always_comb begin
        if (i_st.z[QTH_AW-1]) begin
            n_sum = i_st.z + QTH_FULL_TURN + QTH_ROUND_HALF;
        end else begin
            n_sum = i_st.z + QTH_ROUND_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_raw  <= n_sum[QTH_ROUND_SHIFT +: QTH_HW];
            r_zero <= i_st.zero;
        end
    end

    // Stage 1: wrap a rounded full turn, force the origin to zero
    always_comb begin
        if (r_zero) begin
            n_head = '0;
        end else if (r_raw >= QTH_HEAD_LIMIT) begin
            n_head = r_raw - QTH_HEAD_LIMIT;
        end else begin
            n_head = r_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_head <= n_head;
        end
    end

    assign o_heading = r_head;

endmodule

[src/quaternion_to_heading_top.sv]
// Top level of the quaternion-to-heading block: stage valid bits and flow control.
// Depends on qth_pkg, qth_quat_if, qth_head_if, qth_prod, qth_cordic, qth_heading.
//
// Usage:
//   i_quat carries one quaternion (x, y, z, w), signed Q1.14, per item.
//   o_head returns one heading per item, unsigned, 1/128 degree, 0..46079.
//   Items leave in the order they arrive; every input gives exactly one result.
// Pipeline from accept to o_head.valid: two product stages, one quadrant
//   fold, one stage per CORDIC iteration, and two stages of wrap and rounding.
// Throughput: one item per cycle; each stage has its own register and
//   valid bit, so a new item enters every cycle while the pipeline flows.
// Stall: when o_head.ready is low, the output holds; upstream stages keep
//   advancing into empty slots, and i_quat.ready drops only once every
//   stage holds an item.
// Reset: i_rst_n (synchronous, active low) clears all valid bits; the
//   pipeline comes up empty and ready.
`timescale 1ns / 1ps
`include "quaternion_to_heading_top_defines.svh"

module quaternion_to_heading_top import qth_pkg::*; #(
    parameter int CORDIC_STAGES = QTH_CORDIC_STAGES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qth_quat_if.sink  i_quat,
    qth_head_if.source o_head
);

    localparam int NST = CORDIC_STAGES + 5;

    logic [NST-1:0] r_vld;
    logic [NST-1:0] n_vld;
    logic [NST-1:0] en;
    logic [NST-1:0] vld_in;

    t_rv        r1, r4;
    logic       zero;
    t_cordic_st cst;
    t_head      heading;

    // Stage advance: load when empty or when the next stage moves on
    assign en[NST-1] = !r_vld[NST-1] || o_head.ready;
    for (genvar k = 0; k < NST - 1; k++) begin : g_en
        assign en[k] = !r_vld[k] || en[k+1];
    end

    // Valid bits travel with the data
    assign vld_in = {r_vld[NST-2:0], i_quat.valid};

    always_comb begin
        for (int k = 0; k < NST; k++) begin
            n_vld[k] = en[k] ? vld_in[k] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    qth_prod u_prod (
        .i_clk  (i_clk),
        .i_en   (en[1:0]),
        .i_x    (i_quat.quat_x),
        .i_y    (i_quat.quat_y),
        .i_z    (i_quat.quat_z),
        .i_w    (i_quat.quat_w),
        .o_r1   (r1),
        .o_r4   (r4),
        .o_zero (zero)
    );

    qth_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_en   (en[CORDIC_STAGES+2:2]),
        .i_r1   (r1),
        .i_r4   (r4),
        .i_zero (zero),
        .o_st   (cst)
    );

    qth_heading u_heading (
        .i_clk     (i_clk),
        .i_en      (en[NST-1:NST-2]),
        .i_st      (cst),
        .o_heading (heading)
    );

    assign i_quat.ready   = en[0];
    assign o_head.valid   = r_vld[NST-1];
    assign o_head.heading = heading;

    // Checks
    `QTH_ASSERT_IMPL(a_head_range, i_clk, i_rst_n, o_head.valid, o_head.heading < QTH_HEAD_LIMIT, "heading out of range")
    `QTH_ASSERT_IMPL(a_block_full, i_clk, i_rst_n, !i_quat.ready, &r_vld, "input blocked with an empty stage")
    `QTH_ASSERT_NEXT(a_accept_fill, i_clk, i_rst_n, i_quat.valid && i_quat.ready, r_vld[0], "accepted item lost at entry")

endmodule

[sim/tb_quaternion_to_heading_top.sv]
// Testbench for quaternion_to_heading_top: checks every heading against a local CORDIC predictor.
// Depends on qth_pkg, qth_quat_if, qth_head_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_quaternion_to_heading_top;
    import qth_pkg::*;

    localparam int CORDIC_STAGES = QTH_CORDIC_STAGES_DEF;
    localparam int PIPE_DEPTH    = CORDIC_STAGES + 5;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_MAX    = 10;

    logic i_clk;
    logic i_rst_n;

    qth_quat_if quat_ch ();
    qth_head_if head_ch ();

    quaternion_to_heading_top #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_quat (quat_ch),
        .o_head (head_ch)
    );

    // Expected headings, oldest first
    t_head heading_q[$];

    int  n_sent;
    int  n_checked;
    int  n_errors;
    int  n_in_stall;
    bit  tx_idle_en;
    bit  rx_idle_en;
    int  hold_requests;

    // Clock: 10 ns period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Heading predictor: r1/r4 from the quaternion, CORDIC vectoring in degrees, wrap and round
    function automatic t_head quat_heading(t_quat qx, t_quat qy, t_quat qz, t_quat qw);
        longint r1, r4, vx, vy, ang, sx, sy, tmp, h;
        r1 = 2 * (longint'(qx) * longint'(qy)) - 2 * (longint'(qz) * longint'(qw));
        r4 = (longint'(1) <<< 28) - 2 * (longint'(qx) * longint'(qx))
             - 2 * (longint'(qz) * longint'(qz));
        if (r1 == 0 && r4 == 0) begin
            return '0;
        end
        vx  = r4 * 65536;
        vy  = r1 * 65536;
        ang = 0;
        // Fold the left half plane by a quarter turn
        if (vx < 0) begin
            tmp = vx;
            if (vy >= 0) begin
                vx  = vy;
                vy  = -tmp;
                ang = longint'(QTH_QUARTER);
            end else begin
                vx  = -vy;
                vy  = tmp;
                ang = -longint'(QTH_QUARTER);
            end
        end
        for (int i = 0; i < CORDIC_STAGES && i < QTH_TABLE_LEN; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy >= 0) begin
                vx  = vx + sy;
                vy  = vy - sx;
                ang = ang + longint'(QTH_ATAN_TAB[i]);
            end else begin
                vx  = vx - sy;
                vy  = vy + sx;
                ang = ang - longint'(QTH_ATAN_TAB[i]);
            end
        end
        if (ang < 0) begin
            ang = ang + longint'(QTH_FULL_TURN);
        end
        h = (ang + longint'(QTH_ROUND_HALF)) >>> QTH_ROUND_SHIFT;
        if (h >= longint'(QTH_HEAD_LIMIT)) begin
            h = h - longint'(QTH_HEAD_LIMIT);
        end
        return t_head'(h);
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic t_quat rand_q14();
        int v;
        v = int'($urandom_range(0, 32768)) - 16384;
        return t_quat'(v);
    endfunction

    function automatic t_quat rand_small();
        int v;
        v = int'($urandom_range(0, 128)) - 64;
        return t_quat'(v);
    endfunction

    // Record an expectation for every accepted quaternion
    always @(posedge i_clk) begin
        if (i_rst_n && quat_ch.valid && quat_ch.ready) begin
            heading_q.push_back(quat_heading(quat_ch.quat_x, quat_ch.quat_y,
                                             quat_ch.quat_z, quat_ch.quat_w));
            n_sent++;
        end
        if (i_rst_n && quat_ch.valid && !quat_ch.ready) begin
            n_in_stall++;
        end
    end

    // Compare each accepted heading with the oldest expectation
    always @(posedge i_clk) begin
        t_head exp_head;
        if (i_rst_n && head_ch.valid && head_ch.ready) begin
            if (heading_q.size() == 0) begin
                n_errors++;
                if (n_errors <= REPORT_MAX) begin
                    $display("%0t: unexpected heading %0d, none pending", $realtime,
                             head_ch.heading);
                end
            end else begin
                exp_head = heading_q.pop_front();
                if (head_ch.heading !== exp_head) begin
                    n_errors++;
                    if (n_errors <= REPORT_MAX) begin
                        $display("%0t: heading #%0d mismatch: expected %0d, got %0d",
                                 $realtime, n_checked, exp_head, head_ch.heading);
                    end
                end
            end
            n_checked++;
        end
    end

    // Output side: random stalls, plus a long hold-off on request
    initial begin
        int gap_left;
        int hold_left;
        int holds_seen;
        gap_left      = 0;
        hold_left     = 0;
        holds_seen    = 0;
        head_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_seen) begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                head_ch.ready <= 1'b0;
                hold_left--;
            end else if (gap_left > 0) begin
                head_ch.ready <= 1'b0;
                gap_left--;
            end else begin
                head_ch.ready <= 1'b1;
                if (rx_idle_en) begin
                    gap_left = pick_gap();
                end
            end
        end
    end

    // Offer one quaternion and hold it until accepted
    task automatic send_quat(t_quat qx, t_quat qy, t_quat qz, t_quat qw);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            quat_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        quat_ch.valid  <= 1'b1;
        quat_ch.quat_x <= qx;
        quat_ch.quat_y <= qy;
        quat_ch.quat_z <= qz;
        quat_ch.quat_w <= qw;
        @(posedge i_clk);
        while (!quat_ch.ready) @(posedge i_clk);
    endtask

    // Drop valid and let the pipeline empty out
    task automatic drain();
        quat_ch.valid <= 1'b0;
        while (heading_q.size() > 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
    endtask

    // Extremes, origin, left half plane, negative angle and wrap to zero
    task automatic test_directed();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);         // identity
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);             // all zero
        send_quat(16'sd8192, 16'sd0, 16'sd8192, 16'sd0);       // origin
        send_quat(16'sd8192, 16'sd77, 16'sd8192, 16'sd77);     // origin, y equals w
        send_quat(16'sd8192, 16'sd100, 16'sd8192, 16'sd0);     // r4 zero, r1 positive
        send_quat(16'sd8192, -16'sd100, 16'sd8192, 16'sd0);    // r4 zero, r1 negative
        send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);         // left half, r1 zero
        send_quat(16'sd16384, 16'sd300, 16'sd0, 16'sd0);       // left half, r1 positive
        send_quat(16'sd16384, -16'sd300, 16'sd0, 16'sd0);      // left half, r1 negative
        send_quat(16'sd0, 16'sd0, 16'sd4000, 16'sd9000);       // negative angle
        send_quat(16'sd0, 16'sd0, 16'sd1, 16'sd1);             // rounds to 360, wraps
        send_quat(16'sd0, 16'sd0, -16'sd1, 16'sd1);            // tiny positive angle
        send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
        send_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
        send_quat(16'sd16384, -16'sd16384, -16'sd16384, 16'sd16384);
        send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_quat(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
        send_quat(16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000);
        send_quat(-16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff);
        send_quat(16'sh5555, -16'sh5556, 16'sh2aaa, -16'sh2aab);
        send_quat(16'sd1, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd1, 16'sd0, -16'sd1);
        drain();
    endtask

    // Random quaternions with idling on both sides, in stretches
    task automatic test_random();
        int r;
        t_quat a;
        t_quat b;
        for (int n = 0; n < 400; n++) begin
            if (n % 50 == 0) begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 60) begin
                send_quat(rand_q14(), rand_q14(), rand_q14(), rand_q14());
            end else if (r < 80) begin
                send_quat(t_quat'($urandom), t_quat'($urandom),
                          t_quat'($urandom), t_quat'($urandom));
            end else if (r < 90) begin
                send_quat(rand_small(), rand_small(), rand_small(), rand_small());
            end else begin
                // near the origin or on the r4 = 0 line
                a = rand_q14();
                b = ($urandom_range(0, 1) != 0) ? a : rand_small();
                send_quat(16'sd8192, a, ($urandom_range(0, 1) != 0) ? 16'sd8192 : -16'sd8192,
                          b);
            end
        end
        drain();
    endtask

    // Full rate in both directions
    task automatic test_back_to_back();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int n = 0; n < 50; n++) begin
            send_quat(rand_q14(), rand_q14(), rand_q14(), rand_q14());
        end
        drain();
    endtask

    // Long output hold-off while the input keeps coming: fill the pipeline
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_requests++;
        for (int n = 0; n < 60; n++) begin
            send_quat(rand_q14(), rand_q14(), rand_q14(), rand_q14());
        end
        drain();
    endtask

    initial begin
        n_sent         = 0;
        n_checked      = 0;
        n_errors       = 0;
        n_in_stall     = 0;
        tx_idle_en     = 1'b0;
        rx_idle_en     = 1'b0;
        hold_requests  = 0;
        i_rst_n        = 1'b0;
        quat_ch.valid  = 1'b0;
        quat_ch.quat_x = '0;
        quat_ch.quat_y = '0;
        quat_ch.quat_z = '0;
        quat_ch.quat_w = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random();
        test_back_to_back();
        test_backpressure();

        $display("Sent %0d quaternions (extremes, origin, half-plane folds, wrap, random),",
                 n_sent);
        $display("checked %0d headings; input held off %0d cycles by output stalls, %0d errors",
                 n_checked, n_in_stall, n_errors);
        if (n_errors == 0 && heading_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(5_000_000);
        $display("Timeout with %0d headings outstanding", heading_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
